// ===== rtl/transform_matrix_stack_assert.svh =====
// assertion macros used by the checker file
`ifndef TRANSFORM_MATRIX_STACK_ASSERT_SVH
`define TRANSFORM_MATRIX_STACK_ASSERT_SVH

// same-cycle implication, checked outside reset
`define TMS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("transform matrix stack check failed");

// next-cycle implication, checked outside reset
`define TMS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("transform matrix stack check failed");

`endif

// ===== rtl/tms_pkg.sv =====
// shared types, constants and helpers of the transform matrix stack
package tms_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int ENT_W       = $clog2(STACK_DEPTH);
  localparam int ADDR_W      = 1 + ENT_W + 4;
  localparam int MEM_DEPTH   = 2 ** ADDR_W;

  typedef logic signed [31:0] q_t;
  localparam q_t ONE_Q = 32'sh0001_0000;

  typedef logic [3:0]       elem_t;
  typedef logic [ENT_W-1:0] entry_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [3:0] {
    KIND_RESET     = 4'd0,
    KIND_PUSH      = 4'd1,
    KIND_POP       = 4'd2,
    KIND_CLEAR     = 4'd3,
    KIND_STAGE     = 4'd4,
    KIND_MUL       = 4'd5,
    KIND_TRANSLATE = 4'd6,
    KIND_SCALE     = 4'd7,
    KIND_READ_COMP = 4'd8,
    KIND_READ_TOP  = 4'd9
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_EMPTY     = 2'd3
  } status_e;

  typedef struct packed {
    logic    take;
    logic    a_ident;
    logic    rd_en;
    logic    rd_to_b;
    logic    wr_en;
    logic    sel;
    entry_t  entry;
    elem_t   elem;
    logic    mac_en;
    logic [5:0] mac_idx;
    logic    copy_r;
    logic    fresh_set;
    logic    fresh_both;
    logic    emit;
    logic    resp;
    status_e status;
    logic    last;
  } dp_cmd_t;

  function automatic q_t ident_elem(elem_t i);
    return (i == 4'd0 || i == 4'd5 || i == 4'd10 || i == 4'd15) ? ONE_Q : '0;
  endfunction

endpackage

// ===== rtl/tms_ctrl.sv =====
// sequencer: command decode, stack counts and step counters
module tms_ctrl import tms_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  input  logic [3:0] kind_i,
  input  logic    target_i,
  output logic    busy,
  output dp_cmd_t cmd_o
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_LOADA = 9'b000000010,
    S_LOADB = 9'b000000100,
    S_MAC   = 9'b000001000,
    S_DRAIN = 9'b000010000,
    S_COPY  = 9'b000100000,
    S_WRBK  = 9'b001000000,
    S_RESP  = 9'b010000000,
    S_EMIT  = 9'b100000000
  } state_e;

  state_e     state_q, state_d;
  kind_e      kind_q, kind_d;
  logic       sel_q, sel_d;
  cnt_t       cnt_q [2];
  cnt_t       cnt_d [2];
  elem_t      e_q, e_d;
  logic [5:0] m_q, m_d;
  cnt_t       j_q, j_d;
  cnt_t       cur_cnt, sel_cnt;
  entry_t     top_ent;

  assign cur_cnt = cnt_q[target_i];
  assign sel_cnt = cnt_q[sel_q];
  assign top_ent = ENT_W'(sel_cnt - cnt_t'(1));
  assign busy    = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    kind_d  = kind_q;
    sel_d   = sel_q;
    cnt_d   = cnt_q;
    e_d     = e_q;
    m_d     = m_q;
    j_d     = j_q;
    cmd_o         = '0;
    cmd_o.sel     = sel_q;
    cmd_o.entry   = top_ent;
    cmd_o.elem    = e_q;
    cmd_o.mac_idx = m_q;
    cmd_o.status  = ST_OK;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.take = 1'b1;
          cmd_o.sel  = target_i;
          cmd_o.last = 1'b1;
          kind_d = kind_e'(kind_i);
          sel_d  = target_i;
          e_d    = '0;
          m_d    = '0;
          j_d    = '0;
          unique case (kind_e'(kind_i))
            KIND_RESET: begin
              cnt_d[0] = cnt_t'(1);
              cnt_d[1] = cnt_t'(1);
              cmd_o.fresh_set  = 1'b1;
              cmd_o.fresh_both = 1'b1;
              cmd_o.entry      = '0;
              cmd_o.resp       = 1'b1;
            end
            KIND_PUSH: begin
              cmd_o.resp = 1'b1;
              if (cur_cnt >= cnt_t'(STACK_DEPTH)) begin
                cmd_o.status = ST_OVERFLOW;
              end else begin
                cmd_o.fresh_set  = 1'b1;
                cmd_o.entry      = ENT_W'(cur_cnt);
                cnt_d[target_i]  = cur_cnt + cnt_t'(1);
              end
            end
            KIND_POP: begin
              cmd_o.resp = 1'b1;
              if (cur_cnt == '0) begin
                cmd_o.status = ST_UNDERFLOW;
              end else begin
                cnt_d[target_i] = cur_cnt - cnt_t'(1);
              end
            end
            KIND_CLEAR: begin
              cmd_o.fresh_set = 1'b1;
              cmd_o.entry     = '0;
              cnt_d[target_i] = cnt_t'(1);
              cmd_o.resp      = 1'b1;
            end
            KIND_MUL, KIND_TRANSLATE, KIND_SCALE, KIND_READ_TOP: begin
              if (cur_cnt == '0) begin
                cmd_o.resp   = 1'b1;
                cmd_o.status = ST_EMPTY;
              end else begin
                state_d = S_LOADA;
              end
            end
            KIND_READ_COMP: begin
              cmd_o.a_ident = 1'b1;
              state_d = (cur_cnt == '0) ? S_EMIT : S_LOADB;
            end
            default: begin
              cmd_o.resp = 1'b1;
            end
          endcase
        end
      end
      S_LOADA: begin
        cmd_o.rd_en = 1'b1;
        e_d = e_q + elem_t'(1);
        if (e_q == 4'd15) begin
          state_d = (kind_q == KIND_READ_TOP) ? S_EMIT : S_MAC;
        end
      end
      S_LOADB: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_to_b = 1'b1;
        cmd_o.entry   = j_q[ENT_W-1:0];
        e_d = e_q + elem_t'(1);
        if (e_q == 4'd15) begin
          state_d = S_MAC;
        end
      end
      S_MAC: begin
        cmd_o.mac_en = 1'b1;
        m_d = m_q + 6'd1;
        if (m_q == 6'd63) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = (kind_q == KIND_READ_COMP) ? S_COPY : S_WRBK;
      end
      S_COPY: begin
        cmd_o.copy_r = 1'b1;
        j_d = j_q + cnt_t'(1);
        state_d = (j_d == sel_cnt) ? S_EMIT : S_LOADB;
      end
      S_WRBK: begin
        cmd_o.wr_en = 1'b1;
        e_d = e_q + elem_t'(1);
        if (e_q == 4'd15) begin
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        cmd_o.resp = 1'b1;
        cmd_o.last = 1'b1;
        state_d = S_IDLE;
      end
      S_EMIT: begin
        cmd_o.emit = 1'b1;
        cmd_o.last = (e_q == 4'd15);
        e_d = e_q + elem_t'(1);
        if (e_q == 4'd15) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      kind_q   <= KIND_RESET;
      sel_q    <= 1'b0;
      cnt_q[0] <= cnt_t'(1);
      cnt_q[1] <= cnt_t'(1);
      e_q      <= '0;
      m_q      <= '0;
      j_q      <= '0;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
      sel_q   <= sel_d;
      cnt_q   <= cnt_d;
      e_q     <= e_d;
      m_q     <= m_d;
      j_q     <= j_d;
    end
  end

endmodule

// ===== rtl/tms_dp.sv =====
// datapath: matrix memory, operand registers, shared multiplier, result register
module tms_dp import tms_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  dp_cmd_t cmd_i,
  input  logic [3:0]  kind_i,
  input  logic [3:0]  elem_index_i,
  input  logic signed [31:0] elem_value_i,
  input  logic signed [31:0] x_value_i,
  input  logic signed [31:0] y_value_i,
  input  logic signed [31:0] z_value_i,
  output logic        valid_o,
  output logic [3:0]  out_index_o,
  output logic signed [31:0] out_value_o,
  output logic [1:0]  status_o,
  output logic        last_o
);

  q_t mem_q [MEM_DEPTH];
  logic [STACK_DEPTH-1:0] fresh_q [2];
  q_t staged_q [16];
  q_t a_q [16];
  q_t b_q [16];
  q_t r_q [16];

  logic signed [63:0] p_q;
  logic               p_v_q;
  logic [1:0]         p_k_q;
  elem_t              p_e_q;
  logic signed [65:0] acc_q;
  logic signed [65:0] acc_sum;
  logic signed [49:0] acc_sh;
  q_t                 acc_sat;

  logic [ADDR_W-1:0] addr;
  elem_t a_idx, b_idx;

  assign addr  = {cmd_i.sel, cmd_i.entry, cmd_i.elem};
  // element (c*4+w), term k: a[k*4+w] * b[c*4+k]
  assign a_idx = {cmd_i.mac_idx[1:0], cmd_i.mac_idx[3:2]};
  assign b_idx = {cmd_i.mac_idx[5:4], cmd_i.mac_idx[1:0]};

  always_comb begin
    acc_sum = ((p_k_q == 2'd0) ? 66'sd0 : acc_q) + {{2{p_q[63]}}, p_q};
    acc_sh  = acc_sum[65:16];
    if (acc_sh[49:31] == '0 || acc_sh[49:31] == '1) begin
      acc_sat = acc_sh[31:0];
    end else if (acc_sh[49]) begin
      acc_sat = 32'sh8000_0000;
    end else begin
      acc_sat = 32'sh7fff_ffff;
    end
  end

  // payload: no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[addr] <= r_q[cmd_i.elem];
    end
    if (cmd_i.rd_en) begin
      if (cmd_i.rd_to_b) begin
        b_q[cmd_i.elem] <= fresh_q[cmd_i.sel][cmd_i.entry] ? ident_elem(cmd_i.elem)
                                                           : mem_q[addr];
      end else begin
        a_q[cmd_i.elem] <= fresh_q[cmd_i.sel][cmd_i.entry] ? ident_elem(cmd_i.elem)
                                                           : mem_q[addr];
      end
    end
    if (cmd_i.a_ident) begin
      for (int i = 0; i < 16; i++) begin
        a_q[i] <= ident_elem(elem_t'(i));
      end
    end
    if (cmd_i.copy_r) begin
      a_q <= r_q;
    end
    if (cmd_i.take) begin
      unique case (kind_e'(kind_i))
        KIND_MUL: begin
          b_q <= staged_q;
        end
        KIND_TRANSLATE: begin
          for (int i = 0; i < 16; i++) begin
            if (i == 12) b_q[i] <= x_value_i;
            else if (i == 13) b_q[i] <= y_value_i;
            else if (i == 14) b_q[i] <= z_value_i;
            else b_q[i] <= ident_elem(elem_t'(i));
          end
        end
        KIND_SCALE: begin
          for (int i = 0; i < 16; i++) begin
            if (i == 0) b_q[i] <= x_value_i;
            else if (i == 5) b_q[i] <= y_value_i;
            else if (i == 10) b_q[i] <= z_value_i;
            else if (i == 15) b_q[i] <= ONE_Q;
            else b_q[i] <= '0;
          end
        end
        default: begin
        end
      endcase
    end
    if (cmd_i.mac_en) begin
      p_q   <= a_q[a_idx] * b_q[b_idx];
      p_k_q <= cmd_i.mac_idx[1:0];
      p_e_q <= cmd_i.mac_idx[5:2];
    end
    if (p_v_q) begin
      acc_q <= acc_sum;
      if (p_k_q == 2'd3) begin
        r_q[p_e_q] <= acc_sat;
      end
    end
    if (cmd_i.emit) begin
      out_index_o <= cmd_i.elem;
      out_value_o <= a_q[cmd_i.elem];
      status_o    <= ST_OK;
      last_o      <= cmd_i.last;
    end else if (cmd_i.resp) begin
      out_index_o <= '0;
      out_value_o <= '0;
      status_o    <= cmd_i.status;
      last_o      <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o    <= 1'b0;
      p_v_q      <= 1'b0;
      fresh_q[0] <= STACK_DEPTH'(1);
      fresh_q[1] <= STACK_DEPTH'(1);
      for (int i = 0; i < 16; i++) begin
        staged_q[i] <= ident_elem(elem_t'(i));
      end
    end else begin
      valid_o <= cmd_i.emit | cmd_i.resp;
      p_v_q   <= cmd_i.mac_en;
      if (cmd_i.take && kind_e'(kind_i) == KIND_STAGE) begin
        staged_q[elem_index_i] <= elem_value_i;
      end
      if (cmd_i.fresh_set) begin
        if (cmd_i.fresh_both) begin
          fresh_q[0][0] <= 1'b1;
          fresh_q[1][0] <= 1'b1;
        end else begin
          fresh_q[cmd_i.sel][cmd_i.entry] <= 1'b1;
        end
      end else if (cmd_i.wr_en) begin
        fresh_q[cmd_i.sel][cmd_i.entry] <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/transform_matrix_stack.sv =====
// transform matrix stack top level: sequencer plus datapath
// Two stacks (modelview, projection) of 4x4 Q16.16 matrices, column-major.
// A command is a transfer at a clock edge with start high and busy low. Every
// result is shown on the result ports for one cycle with valid_o high and the
// receiver must take it then; it cannot stall the block. Push, pop, clear,
// reset, stage and unused kinds stay in the idle state and their single result
// appears in the next cycle, so such commands can follow each other every
// cycle. Multiply, translate and scale on a non-empty stack go through the
// accepting cycle, the loading of the 16 top elements from the single-port
// matrix memory, 64 multiply-accumulate steps on the one shared 32x32
// multiplier, a drain step, the write-back of 16 elements and the result.
// Read top: the accepting cycle, 16 loads, 16 results. Read composite
// starts from the identity; each of the n stack entries is loaded (16
// elements) and multiplied in (64 steps, drain, copy), then 16 stream out.
// No clearing pass after reset: one valid bit per stack entry marks entries
// that still hold the identity, so a push or clear writes no matrix memory.
module transform_matrix_stack import tms_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  kind_i,
  input  logic        target_i,
  input  logic [3:0]  elem_index_i,
  input  logic signed [31:0] elem_value_i,
  input  logic signed [31:0] x_value_i,
  input  logic signed [31:0] y_value_i,
  input  logic signed [31:0] z_value_i,
  output logic        valid_o,
  output logic [3:0]  out_index_o,
  output logic signed [31:0] out_value_o,
  output logic [1:0]  status_o,
  output logic        last_o
);

  // command bundle from sequencer to datapath
  dp_cmd_t cmd;

  // sequencer: decode, stack counts, load / multiply / write / emit steps
  tms_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .kind_i   (kind_i),
    .target_i (target_i),
    .busy     (busy),
    .cmd_o    (cmd)
  );

  // datapath: matrix memory, operands, multiplier, registered result
  tms_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .kind_i       (kind_i),
    .elem_index_i (elem_index_i),
    .elem_value_i (elem_value_i),
    .x_value_i    (x_value_i),
    .y_value_i    (y_value_i),
    .z_value_i    (z_value_i),
    .valid_o      (valid_o),
    .out_index_o  (out_index_o),
    .out_value_o  (out_value_o),
    .status_o     (status_o),
    .last_o       (last_o)
  );

endmodule

// ===== rtl/tms_checker.sv =====
// port-level checks of the transform matrix stack, bound to the top level
`include "transform_matrix_stack_assert.svh"

module tms_checker import tms_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic [3:0]  kind_i,
  input logic        valid_o,
  input logic [3:0]  out_index_o,
  input logic [1:0]  status_o,
  input logic        last_o
);

  logic simple_kind;
  assign simple_kind = !(kind_i == KIND_MUL || kind_i == KIND_TRANSLATE ||
                         kind_i == KIND_SCALE || kind_i == KIND_READ_COMP ||
                         kind_i == KIND_READ_TOP);

  // a one-step command answers in the next cycle with a single result
  `TMS_ASSERT_NXT(a_simple_resp, start && !busy && simple_kind, valid_o && last_o)
  // a read streams its 16 results back to back
  `TMS_ASSERT_NXT(a_read_burst, valid_o && !last_o, valid_o)
  // element positions count up through a read
  `TMS_ASSERT_NXT(a_read_index, valid_o && !last_o,
                  out_index_o == 4'($past(out_index_o) + 4'd1))
  // read elements before the last always carry ok status
  `TMS_ASSERT_IMP(a_read_status, valid_o && !last_o, status_o == ST_OK)

endmodule

bind transform_matrix_stack tms_checker u_tms_checker (.*);

// ===== tb/sv/tb_transform_matrix_stack.sv =====
// testbench of the transform matrix stack: directed table, random commands, self-checking
`timescale 1ns / 100ps

module tb_transform_matrix_stack;
  import tms_pkg::*;

  typedef q_t mat_t [16];

  // one command as the sender drives it
  typedef struct {
    logic [3:0] kind;
    logic       target;
    logic [3:0] idx;
    q_t         ev;
    q_t         xv;
    q_t         yv;
    q_t         zv;
    logic       typed;   // status below is typed in by hand
    status_e    st;
  } cmd_t;

  // one result as the block should show it
  typedef struct {
    logic [3:0] idx;
    q_t         val;
    logic [1:0] st;
    logic       last;
  } elem_out_t;

  logic       clk_i;
  logic       rst_ni;
  logic       start;
  logic       busy;
  logic [3:0] kind_i;
  logic       target_i;
  logic [3:0] elem_index_i;
  logic signed [31:0] elem_value_i;
  logic signed [31:0] x_value_i;
  logic signed [31:0] y_value_i;
  logic signed [31:0] z_value_i;
  logic       valid_o;
  logic [3:0] out_index_o;
  logic signed [31:0] out_value_o;
  logic [1:0] status_o;
  logic       last_o;

  transform_matrix_stack dut (
    .clk_i, .rst_ni, .start, .busy, .kind_i, .target_i, .elem_index_i,
    .elem_value_i, .x_value_i, .y_value_i, .z_value_i, .valid_o,
    .out_index_o, .out_value_o, .status_o, .last_o
  );

  // shadow state of both stacks and the staged matrix
  mat_t      shadow_stack [2][STACK_DEPTH];
  int        shadow_count [2];
  mat_t      shadow_staged;
  elem_out_t pending_elems [$];
  int        errors = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic mat_t ident_mat();
    mat_t m;
    for (int i = 0; i < 16; i++) m[i] = (i % 5 == 0) ? ONE_Q : '0;
    return m;
  endfunction

  // a * b column-major, exact four-term sum, floor to Q16.16, saturate
  function automatic mat_t mat_product(mat_t a, mat_t b);
    mat_t r;
    logic signed [65:0] acc;
    logic signed [49:0] shifted;
    for (int c = 0; c < 4; c++) begin
      for (int w = 0; w < 4; w++) begin
        acc = '0;
        for (int k = 0; k < 4; k++) acc += 66'(a[k*4+w]) * 66'(b[c*4+k]);
        shifted = 50'(acc >>> 16);
        if (shifted > 50'sd2147483647) r[c*4+w] = 32'sh7fff_ffff;
        else if (shifted < -50'sd2147483648) r[c*4+w] = 32'sh8000_0000;
        else r[c*4+w] = shifted[31:0];
      end
    end
    return r;
  endfunction

  task automatic queue_elem(logic [3:0] idx, q_t val, logic [1:0] st, logic last);
    elem_out_t e;
    e.idx = idx; e.val = val; e.st = st; e.last = last;
    pending_elems.push_back(e);
  endtask

  // update the shadow state for one accepted command and queue its results
  task automatic predict_cmd(cmd_t c);
    mat_t    m;
    status_e st;
    int      t;
    int      n;
    st = ST_OK;
    t = c.target;
    n = shadow_count[t];
    case (c.kind)
      KIND_RESET: begin
        shadow_count[0] = 1;
        shadow_count[1] = 1;
        shadow_stack[0][0] = ident_mat();
        shadow_stack[1][0] = ident_mat();
      end
      KIND_PUSH: begin
        if (n >= STACK_DEPTH) st = ST_OVERFLOW;
        else begin
          shadow_stack[t][n] = ident_mat();
          shadow_count[t] = n + 1;
        end
      end
      KIND_POP: begin
        if (n == 0) st = ST_UNDERFLOW;
        else shadow_count[t] = n - 1;
      end
      KIND_CLEAR: begin
        shadow_stack[t][0] = ident_mat();
        shadow_count[t] = 1;
      end
      KIND_STAGE: shadow_staged[c.idx] = c.ev;
      KIND_MUL, KIND_TRANSLATE, KIND_SCALE: begin
        if (n == 0) st = ST_EMPTY;
        else begin
          if (c.kind == KIND_MUL) m = shadow_staged;
          else if (c.kind == KIND_TRANSLATE) begin
            m = ident_mat();
            m[12] = c.xv; m[13] = c.yv; m[14] = c.zv;
          end else begin
            for (int i = 0; i < 16; i++) m[i] = '0;
            m[0] = c.xv; m[5] = c.yv; m[10] = c.zv; m[15] = ONE_Q;
          end
          shadow_stack[t][n-1] = mat_product(shadow_stack[t][n-1], m);
        end
      end
      KIND_READ_COMP: begin
        m = ident_mat();
        for (int j = 0; j < n; j++) m = mat_product(m, shadow_stack[t][j]);
        for (int i = 0; i < 16; i++) queue_elem(4'(i), m[i], ST_OK, i == 15);
        return;
      end
      KIND_READ_TOP: begin
        if (n == 0) st = ST_EMPTY;
        else begin
          for (int i = 0; i < 16; i++)
            queue_elem(4'(i), shadow_stack[t][n-1][i], ST_OK, i == 15);
          return;
        end
      end
      default: ;
    endcase
    // hand-typed status wins for directed rows
    if (c.typed) st = c.st;
    queue_elem(4'd0, '0, st, 1'b1);
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // result side: the block cannot be held off, take every strobe
  always @(posedge clk_i) begin
    elem_out_t e;
    if (rst_ni && valid_o) begin
      if (pending_elems.size() == 0) begin
        report_mismatch("unexpected result index", out_index_o, -1);
      end else begin
        e = pending_elems.pop_front();
        if (out_index_o !== e.idx) report_mismatch("out_index", out_index_o, e.idx);
        if (out_value_o !== e.val) report_mismatch("out_value", out_value_o, e.val);
        if (status_o !== e.st) report_mismatch("status", status_o, e.st);
        if (last_o !== e.last) report_mismatch("last", last_o, e.last);
      end
    end
  end

  // one transfer: optional gap, then hold start until the block takes it
  task automatic send_cmd(cmd_t c, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start        <= 1'b1;
    kind_i       <= c.kind;
    target_i     <= c.target;
    elem_index_i <= c.idx;
    elem_value_i <= c.ev;
    x_value_i    <= c.xv;
    y_value_i    <= c.yv;
    z_value_i    <= c.zv;
    do @(posedge clk_i); while (busy);
    predict_cmd(c);
  endtask

  function automatic cmd_t mk(logic [3:0] k, logic t, logic [3:0] i, q_t e,
                              q_t x, q_t y, q_t z);
    cmd_t c;
    c.kind = k; c.target = t; c.idx = i; c.ev = e;
    c.xv = x; c.yv = y; c.zv = z; c.typed = 1'b0; c.st = ST_OK;
    return c;
  endfunction

  function automatic cmd_t mk_st(logic [3:0] k, logic t, status_e s);
    cmd_t c;
    c = mk(k, t, 4'd0, '0, '0, '0, '0);
    c.typed = 1'b1;
    c.st = s;
    return c;
  endfunction

  // mostly modest Q16.16 values, sometimes extremes or raw 32-bit noise
  function automatic q_t rand_q();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return q_t'($urandom);
    if (r == 1) return ($urandom_range(0, 1) == 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
    return q_t'(int'($urandom_range(0, 8 * 65536)) - 4 * 65536);
  endfunction

  function automatic cmd_t rand_cmd();
    cmd_t c;
    int   r;
    c = mk(4'd0, 1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
           rand_q(), rand_q(), rand_q(), rand_q());
    r = $urandom_range(0, 99);
    if (r < 6) c.kind = KIND_READ_COMP;
    else if (r < 15) c.kind = KIND_READ_TOP;
    else if (r < 30) c.kind = KIND_STAGE;
    else if (r < 40) c.kind = KIND_MUL;
    else if (r < 48) c.kind = KIND_TRANSLATE;
    else if (r < 56) c.kind = KIND_SCALE;
    else if (r < 72) c.kind = KIND_PUSH;
    else if (r < 85) c.kind = KIND_POP;
    else if (r < 89) c.kind = KIND_CLEAR;
    else if (r < 92) c.kind = KIND_RESET;
    else c.kind = 4'($urandom_range(10, 15));
    return c;
  endfunction

  cmd_t directed_rows [$];

  initial begin
    rst_ni       = 1'b0;
    start        = 1'b0;
    kind_i       = '0;
    target_i     = 1'b0;
    elem_index_i = '0;
    elem_value_i = '0;
    x_value_i    = '0;
    y_value_i    = '0;
    z_value_i    = '0;
    for (int t = 0; t < 2; t++) begin
      shadow_stack[t][0] = ident_mat();
      shadow_count[t] = 1;
    end
    shadow_staged = ident_mat();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty-stack cases, extremes of the operands, every kind
    directed_rows.push_back(mk(KIND_READ_COMP, 1'b0, 4'd0, '0, '0, '0, '0));
    directed_rows.push_back(mk(KIND_READ_TOP, 1'b1, 4'd0, '0, '0, '0, '0));
    directed_rows.push_back(mk_st(KIND_POP, 1'b0, ST_OK));
    directed_rows.push_back(mk_st(KIND_POP, 1'b0, ST_UNDERFLOW));
    directed_rows.push_back(mk_st(KIND_MUL, 1'b0, ST_EMPTY));
    directed_rows.push_back(mk_st(KIND_TRANSLATE, 1'b0, ST_EMPTY));
    directed_rows.push_back(mk_st(KIND_SCALE, 1'b0, ST_EMPTY));
    directed_rows.push_back(mk_st(KIND_READ_TOP, 1'b0, ST_EMPTY));
    directed_rows.push_back(mk(KIND_READ_COMP, 1'b0, 4'd0, '0, '0, '0, '0));
    directed_rows.push_back(mk_st(KIND_PUSH, 1'b0, ST_OK));
    directed_rows.push_back(mk(KIND_STAGE, 1'b0, 4'd0, 32'sh7fff_ffff, '0, '0, '0));
    directed_rows.push_back(mk(KIND_STAGE, 1'b1, 4'd15, 32'sh8000_0000, '0, '0, '0));
    directed_rows.push_back(mk(KIND_STAGE, 1'b0, 4'd7, 32'shffff_ffff, '0, '0, '0));
    directed_rows.push_back(mk(KIND_MUL, 1'b0, 4'd0, '0, '0, '0, '0));
    directed_rows.push_back(mk(KIND_READ_TOP, 1'b0, 4'd0, '0, '0, '0, '0));
    directed_rows.push_back(mk(KIND_SCALE, 1'b1, 4'd0, '0, 32'sh7fff_ffff,
                               32'sh8000_0000, 32'sh0000_0001));
    directed_rows.push_back(mk(KIND_TRANSLATE, 1'b1, 4'd0, '0, 32'sh8000_0000,
                               32'sh7fff_ffff, 32'shffff_ffff));
    directed_rows.push_back(mk(KIND_READ_TOP, 1'b1, 4'd0, '0, '0, '0, '0));
    directed_rows.push_back(mk(KIND_READ_COMP, 1'b1, 4'd0, '0, '0, '0, '0));
    directed_rows.push_back(mk_st(4'd15, 1'b1, ST_OK));
    directed_rows.push_back(mk_st(KIND_CLEAR, 1'b1, ST_OK));
    directed_rows.push_back(mk_st(KIND_RESET, 1'b1, ST_OK));
    directed_rows.push_back(mk(KIND_READ_COMP, 1'b0, 4'd0, '0, '0, '0, '0));
    foreach (directed_rows[i]) send_cmd(directed_rows[i], $urandom_range(0, 9));

    // fill the projection stack to the top, then one push too many
    for (int i = 1; i < STACK_DEPTH; i++)
      send_cmd(mk_st(KIND_PUSH, 1'b1, ST_OK), $urandom_range(0, 2));
    send_cmd(mk_st(KIND_PUSH, 1'b1, ST_OVERFLOW), 0);
    send_cmd(mk(KIND_SCALE, 1'b1, 4'd0, '0, 32'sh0002_0000, 32'sh0000_8000,
                32'shfffe_0000), 0);
    send_cmd(mk(KIND_READ_COMP, 1'b1, 4'd0, '0, '0, '0, '0), 0);

    // hold off until the block has drained everything
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_elems.size() != 0) @(posedge clk_i);

    // random part, with bursts of back-to-back transfers
    for (int n = 0; n < 230; n++) begin
      if ((n / 30) % 3 == 1) send_cmd(rand_cmd(), 0);
      else send_cmd(rand_cmd(), $urandom_range(0, 9));
    end
    start <= 1'b0;

    while (pending_elems.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (errors == 0 && pending_elems.size() == 0)
      $display("tb_transform_matrix_stack: done, clean");
    else
      $display("tb_transform_matrix_stack: done, errors");
    $finish;
  end

  // generous limit: every item a full-depth composite read plus its gap
  initial begin
    #20ms;
    $display("tb_transform_matrix_stack: done, errors");
    $finish;
  end

endmodule

// ===== transform_matrix_stack.f =====
+incdir+rtl
rtl/tms_pkg.sv
rtl/tms_ctrl.sv
rtl/tms_dp.sv
rtl/transform_matrix_stack.sv
rtl/tms_checker.sv
tb/sv/tb_transform_matrix_stack.sv
